// File: src/rsvm_pkg.sv
package rsvm_pkg;

    localparam int DATA_W          = 8;
    localparam int REQ_W           = 4;
    localparam int PK_W            = 2;
    localparam int NUM_REGS        = 5;
    localparam int REG_IDX_W       = 3;
    localparam int FLAG_W          = 6;
    localparam int STACK_DEPTH_DEF = 256;
    localparam int DIV_STEPS       = 8;

    localparam logic [DATA_W-1:0] SEL_FIRST = 8'hC1;
    localparam logic [DATA_W-1:0] SEL_LAST  = 8'hC5;

    localparam int FL_ABOVE       = 0;
    localparam int FL_EQUAL       = 1;
    localparam int FL_ABOVE_EQUAL = 2;
    localparam int FL_BELOW       = 3;
    localparam int FL_BELOW_EQUAL = 4;
    localparam int FL_NOT_EQUAL   = 5;

    typedef enum logic [REQ_W-1:0] {
        OP_PUSH = 4'd0,
        OP_POP  = 4'd1,
        OP_MOV  = 4'd2,
        OP_ADD  = 4'd3,
        OP_SUB  = 4'd4,
        OP_MUL  = 4'd5,
        OP_DIV  = 4'd6,
        OP_INC  = 4'd7,
        OP_DEC  = 4'd8,
        OP_PUT  = 4'd9,
        OP_JMP  = 4'd10,
        OP_CMP  = 4'd11
    } t_op;

    typedef enum logic [PK_W-1:0] {
        PK_NONE = 2'd0,
        PK_REG  = 2'd1,
        PK_CHAR = 2'd2
    } t_print_kind;

    typedef struct packed {
        logic accept;
        logic exec;
        logic pop_wb;
        logic div_wb;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic pop_reg;
        logic div_reg;
        logic div_done;
    } t_status;

    function automatic logic is_reg(input logic [DATA_W-1:0] v);
        return (v >= SEL_FIRST) && (v <= SEL_LAST);
    endfunction

endpackage

// File: src/register_stack_vm_execute_unit.sv
// Execute unit of a small register and stack byte machine.
// The input channel (i_in_valid / o_in_ready) takes one decoded instruction per
// transaction: i_req_type, i_operand_a and i_operand_b. The output channel
// (o_out_valid / i_out_ready) returns exactly one result per instruction, in order:
// the print request and the instruction pointer, stack pointer and compare flags
// as they stand after that instruction.
// Each instruction passes from the execute state to the done state, where its
// result is loaded; a pop into a register passes a read state on the way
// (registered stack memory read), and a divide into a register waits in a divide
// state while the divider yields one quotient bit per cycle. A new instruction is
// taken in the same cycle a result is loaded, never while one is in progress.
// The result sits in an output register; while the receiver stalls, one more
// instruction may execute, and the block then holds off new input until the
// waiting result has been taken.
// Synchronous reset clears the registers, pointers and flags, and marks the
// whole stack as zero at once; the block is ready in the first cycle after reset.
module register_stack_vm_execute_unit #(
    parameter int STACK_DEPTH = rsvm_pkg::STACK_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [rsvm_pkg::REQ_W-1:0]  i_req_type,
    input  logic [rsvm_pkg::DATA_W-1:0] i_operand_a,
    input  logic [rsvm_pkg::DATA_W-1:0] i_operand_b,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rsvm_pkg::PK_W-1:0]   o_print_kind,
    output logic [rsvm_pkg::DATA_W-1:0] o_print_value,
    output logic [rsvm_pkg::DATA_W-1:0] o_ip_now,
    output logic [rsvm_pkg::DATA_W-1:0] o_sp_now,
    output logic                        o_flag_above,
    output logic                        o_flag_equal,
    output logic                        o_flag_above_equal,
    output logic                        o_flag_below,
    output logic                        o_flag_below_equal,
    output logic                        o_flag_not_equal
);

    rsvm_pkg::t_cmd              cmd;
    rsvm_pkg::t_status           status;
    logic [rsvm_pkg::FLAG_W-1:0] flags;

    rsvm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rsvm_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_req_type    (i_req_type),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .o_print_kind  (o_print_kind),
        .o_print_value (o_print_value),
        .o_ip_now      (o_ip_now),
        .o_sp_now      (o_sp_now),
        .o_flags       (flags)
    );

    assign o_flag_above       = flags[rsvm_pkg::FL_ABOVE];
    assign o_flag_equal       = flags[rsvm_pkg::FL_EQUAL];
    assign o_flag_above_equal = flags[rsvm_pkg::FL_ABOVE_EQUAL];
    assign o_flag_below       = flags[rsvm_pkg::FL_BELOW];
    assign o_flag_below_equal = flags[rsvm_pkg::FL_BELOW_EQUAL];
    assign o_flag_not_equal   = flags[rsvm_pkg::FL_NOT_EQUAL];

endmodule

// File: src/rsvm_divider.sv
module rsvm_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rsvm_pkg::DATA_W-1:0] i_dividend,
    input  logic [rsvm_pkg::DATA_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [rsvm_pkg::DATA_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(rsvm_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rsvm_pkg::DIV_STEPS - 1);

    logic                        r_busy;
    logic [CNT_W-1:0]            r_cnt;
    logic [rsvm_pkg::DATA_W-1:0] r_rem;
    logic [rsvm_pkg::DATA_W-1:0] r_quo;
    logic [rsvm_pkg::DATA_W-1:0] r_dvs;
    logic [rsvm_pkg::DATA_W:0]   rem_shift;
    logic                        fits;
    logic [rsvm_pkg::DATA_W-1:0] n_rem;
    logic [rsvm_pkg::DATA_W-1:0] n_quo;

    // A zero divisor always fits, so the quotient comes out as all ones.
    always_comb begin
        rem_shift = {r_rem, r_quo[rsvm_pkg::DATA_W-1]};
        fits      = rem_shift >= {1'b0, r_dvs};
        n_rem     = fits ? rsvm_pkg::DATA_W'(rem_shift - {1'b0, r_dvs})
                         : rem_shift[rsvm_pkg::DATA_W-1:0];
        n_quo     = {r_quo[rsvm_pkg::DATA_W-2:0], fits};
    end

    assign o_done     = r_busy && (r_cnt == CNT_LAST);
    assign o_quotient = n_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

endmodule

// File: src/rsvm_ctrl.sv
module rsvm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rsvm_pkg::t_status i_status,
    output rsvm_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_load;
    logic   accept;

    always_comb begin
        out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
        o_in_ready  = (r_state == S_IDLE) || out_load;
        accept      = i_in_valid && o_in_ready;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.pop_reg) begin
                    n_state = S_READ;
                end else if (i_status.div_reg) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: n_state = S_DONE;
            S_DIV: begin
                if (i_status.div_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) n_state = accept ? S_EXEC : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.accept   = accept;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.pop_wb   = (r_state == S_READ);
        o_cmd.div_wb   = (r_state == S_DIV) && i_status.div_done;
        o_cmd.out_load = out_load;
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: src/rsvm_datapath.sv
module rsvm_datapath #(
    parameter int STACK_DEPTH = rsvm_pkg::STACK_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rsvm_pkg::t_cmd              i_cmd,
    output rsvm_pkg::t_status           o_status,
    input  logic [rsvm_pkg::REQ_W-1:0]  i_req_type,
    input  logic [rsvm_pkg::DATA_W-1:0] i_operand_a,
    input  logic [rsvm_pkg::DATA_W-1:0] i_operand_b,
    output logic [rsvm_pkg::PK_W-1:0]   o_print_kind,
    output logic [rsvm_pkg::DATA_W-1:0] o_print_value,
    output logic [rsvm_pkg::DATA_W-1:0] o_ip_now,
    output logic [rsvm_pkg::DATA_W-1:0] o_sp_now,
    output logic [rsvm_pkg::FLAG_W-1:0] o_flags
);

    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);
    localparam int DW = rsvm_pkg::DATA_W;

    rsvm_pkg::t_op                   r_op;
    logic [DW-1:0]                   r_a;
    logic [DW-1:0]                   r_b;
    logic [DW-1:0]                   r_gpr [rsvm_pkg::NUM_REGS];
    logic [SP_W-1:0]                 r_sp;
    logic [DW-1:0]                   r_ip;
    logic [rsvm_pkg::FLAG_W-1:0]     r_flags;
    rsvm_pkg::t_print_kind           r_pkind;
    logic [DW-1:0]                   r_pval;
    logic [DW-1:0]                   r_mem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0]          r_valid;
    logic [DW-1:0]                   r_rd_data;
    logic                            r_rd_vld;

    logic                            a_is_reg;
    logic                            b_is_reg;
    logic [rsvm_pkg::REG_IDX_W-1:0]  a_idx;
    logic [rsvm_pkg::REG_IDX_W-1:0]  b_idx;
    logic [DW-1:0]                   val_a;
    logic [DW-1:0]                   val_b;
    logic [2*DW-1:0]                 prod;
    logic [DW-1:0]                   alu;
    logic [rsvm_pkg::FLAG_W-1:0]     cmp_flags;
    logic [SP_W-1:0]                 sp_inc;
    logic [SP_W-1:0]                 sp_dec;
    logic                            mem_we;
    logic [DW-1:0]                   mem_wdata;
    logic                            mem_re;
    logic [DW-1:0]                   rd_value;
    logic                            div_start;
    logic                            div_done;
    logic [DW-1:0]                   quotient;

    always_comb begin
        a_is_reg  = rsvm_pkg::is_reg(r_a);
        b_is_reg  = rsvm_pkg::is_reg(r_b);
        a_idx     = rsvm_pkg::REG_IDX_W'(r_a - rsvm_pkg::SEL_FIRST);
        b_idx     = rsvm_pkg::REG_IDX_W'(r_b - rsvm_pkg::SEL_FIRST);
        val_a     = a_is_reg ? r_gpr[a_idx] : r_a;
        val_b     = b_is_reg ? r_gpr[b_idx] : r_b;
        prod      = val_a * val_b;
        sp_inc    = (r_sp == SP_LAST) ? '0 : SP_W'(r_sp + 1'b1);
        sp_dec    = (r_sp == '0) ? SP_LAST : SP_W'(r_sp - 1'b1);
        rd_value  = r_rd_vld ? r_rd_data : '0;
        case (r_op)
            rsvm_pkg::OP_ADD: alu = DW'(val_a + val_b);
            rsvm_pkg::OP_SUB: alu = DW'(val_a - val_b);
            rsvm_pkg::OP_MUL: alu = prod[DW-1:0];
            default:          alu = val_b;
        endcase
        cmp_flags = '0;
        if (val_a < val_b) begin
            cmp_flags[rsvm_pkg::FL_ABOVE]       = 1'b1;
            cmp_flags[rsvm_pkg::FL_ABOVE_EQUAL] = 1'b1;
            cmp_flags[rsvm_pkg::FL_NOT_EQUAL]   = 1'b1;
        end else if (val_a > val_b) begin
            cmp_flags[rsvm_pkg::FL_BELOW]       = 1'b1;
            cmp_flags[rsvm_pkg::FL_BELOW_EQUAL] = 1'b1;
            cmp_flags[rsvm_pkg::FL_NOT_EQUAL]   = 1'b1;
        end else begin
            cmp_flags[rsvm_pkg::FL_EQUAL]       = 1'b1;
            cmp_flags[rsvm_pkg::FL_ABOVE_EQUAL] = 1'b1;
            cmp_flags[rsvm_pkg::FL_BELOW_EQUAL] = 1'b1;
        end
        mem_we    = i_cmd.exec && ((r_op == rsvm_pkg::OP_PUSH) || (r_op == rsvm_pkg::OP_MOV)
                    || (r_op == rsvm_pkg::OP_ADD) || (r_op == rsvm_pkg::OP_SUB)
                    || (r_op == rsvm_pkg::OP_MUL) || (r_op == rsvm_pkg::OP_DIV));
        mem_wdata = (r_op == rsvm_pkg::OP_PUSH) ? val_a : val_b;
        mem_re    = i_cmd.exec && (r_op == rsvm_pkg::OP_POP) && a_is_reg;
        div_start = i_cmd.exec && (r_op == rsvm_pkg::OP_DIV) && a_is_reg;
    end

    always_comb begin
        o_status.pop_reg  = (r_op == rsvm_pkg::OP_POP) && a_is_reg;
        o_status.div_reg  = (r_op == rsvm_pkg::OP_DIV) && a_is_reg;
        o_status.div_done = div_done;
    end

    rsvm_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (val_a),
        .i_divisor  (val_b),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op <= rsvm_pkg::t_op'(i_req_type);
            r_a  <= i_operand_a;
            r_b  <= i_operand_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_sp] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[sp_dec];
        end
    end

    // Entries never written read as zero, matching a cleared stack.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_valid[r_sp] <= 1'b1;
            end
            if (mem_re) begin
                r_rd_vld <= r_valid[sp_dec];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rsvm_pkg::NUM_REGS; i++) begin
                r_gpr[i] <= '0;
            end
            r_sp    <= '0;
            r_ip    <= '0;
            r_flags <= '0;
            r_pkind <= rsvm_pkg::PK_NONE;
            r_pval  <= '0;
        end else begin
            if (i_cmd.exec) begin
                if (r_op == rsvm_pkg::OP_PUT) begin
                    r_pkind <= a_is_reg ? rsvm_pkg::PK_REG : rsvm_pkg::PK_CHAR;
                    r_pval  <= val_a;
                end else begin
                    r_pkind <= rsvm_pkg::PK_NONE;
                    r_pval  <= '0;
                end
                case (r_op)
                    rsvm_pkg::OP_PUSH: r_sp <= sp_inc;
                    rsvm_pkg::OP_POP: begin
                        if (a_is_reg) r_sp <= sp_dec;
                    end
                    rsvm_pkg::OP_MOV, rsvm_pkg::OP_ADD, rsvm_pkg::OP_SUB,
                    rsvm_pkg::OP_MUL, rsvm_pkg::OP_DIV: begin
                        if (!a_is_reg) begin
                            r_sp <= sp_inc;
                        end else if (r_op != rsvm_pkg::OP_DIV) begin
                            r_gpr[a_idx] <= alu;
                        end
                    end
                    rsvm_pkg::OP_INC: begin
                        if (a_is_reg) r_gpr[a_idx] <= DW'(val_a + 1'b1);
                    end
                    rsvm_pkg::OP_DEC: begin
                        if (a_is_reg) r_gpr[a_idx] <= DW'(val_a - 1'b1);
                    end
                    rsvm_pkg::OP_JMP: r_ip <= r_a;
                    rsvm_pkg::OP_CMP: r_flags <= cmp_flags;
                    default: ;
                endcase
            end
            if (i_cmd.pop_wb) begin
                r_gpr[a_idx] <= rd_value;
            end
            if (i_cmd.div_wb) begin
                r_gpr[a_idx] <= quotient;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_print_kind  <= r_pkind;
            o_print_value <= r_pval;
            o_ip_now      <= r_ip;
            o_sp_now      <= DW'(r_sp);
            o_flags       <= r_flags;
        end
    end

endmodule

// File: src/rsvm_checker.sv
module rsvm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [rsvm_pkg::REQ_W-1:0]  i_req_type,
    input logic [rsvm_pkg::DATA_W-1:0] i_operand_a,
    input logic [rsvm_pkg::DATA_W-1:0] i_operand_b,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [rsvm_pkg::PK_W-1:0]   o_print_kind,
    input logic [rsvm_pkg::DATA_W-1:0] o_print_value,
    input logic [rsvm_pkg::DATA_W-1:0] o_ip_now,
    input logic [rsvm_pkg::DATA_W-1:0] o_sp_now,
    input logic                        o_flag_above,
    input logic                        o_flag_equal,
    input logic                        o_flag_above_equal,
    input logic                        o_flag_below,
    input logic                        o_flag_below_equal,
    input logic                        o_flag_not_equal
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_print_kind)
        && $stable(o_print_value) && $stable(o_ip_now) && $stable(o_sp_now))
        else $error("Result changed while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Input taken in the cycle after a transaction.");

    a_flags_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_flag_above_equal == (o_flag_above || o_flag_equal))
        && (o_flag_below_equal == (o_flag_below || o_flag_equal))
        && !(o_flag_above && o_flag_below)
        && !(o_flag_equal && o_flag_not_equal))
        else $error("Compare flags are inconsistent.");

    a_print_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_print_kind == rsvm_pkg::PK_NONE) |-> o_print_value == '0)
        else $error("Print value without a print request.");

endmodule

bind register_stack_vm_execute_unit rsvm_checker u_rsvm_checker (.*);
